[hdl/tasd_pkg.sv]
// tasd_pkg: types, constants and the coil sequence function for the
// three-axis stepper drive; no dependencies
`default_nettype none

package tasd_pkg;

  localparam int unsigned STEP_COUNT_BITS_DEFAULT = 16;
  localparam int unsigned PERIOD_BITS_DEFAULT     = 24;
  localparam int unsigned XY_PERIOD_RESET         = 20000;
  localparam int unsigned Z_PERIOD_RESET          = 120000;

  typedef enum logic [0:0] {
    CFG_XY_PERIOD = 1'b0,
    CFG_Z_PERIOD  = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    ACTION_TICK = 1'b0,
    ACTION_LOAD = 1'b1
  } action_t;

  localparam logic [3:0] COILS_OFF = 4'h0;
  localparam logic [3:0] COILS_A   = 4'hA;
  localparam logic [3:0] COILS_B   = 4'h6;
  localparam logic [3:0] COILS_C   = 4'h5;
  localparam logic [3:0] COILS_D   = 4'h9;

  typedef struct packed {
    logic       x_step_pin;
    logic       y_step_pin;
    logic       x_dir_pin;
    logic       y_dir_pin;
    logic [3:0] z_coils;
    logic       busy_res;
  } result_t;

  // full-step pattern for a phase; raising runs the lowering order from phase 2
  function automatic logic [3:0] coil_step(input logic [1:0] phase, input logic lower);
    logic [1:0] idx;
    logic [3:0] pat;
    idx = lower ? phase : phase + 2'd2;
    case (idx)
      2'd0:    pat = COILS_A;
      2'd1:    pat = COILS_B;
      2'd2:    pat = COILS_C;
      2'd3:    pat = COILS_D;
      default: pat = COILS_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[hdl/tasd_divider.sv]
// tasd_divider: programmable tick divider, fires once every period ticks
// depends on tasd_pkg for the default width
`default_nettype none

module tasd_divider #(
  parameter int unsigned PERIOD_BITS = tasd_pkg::PERIOD_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   tick,
  input  wire logic [PERIOD_BITS-1:0] period,
  output logic                        fire
);

  logic [PERIOD_BITS-1:0] timer;
  logic [PERIOD_BITS:0]   count_inc;

  assign count_inc = {1'b0, timer} + {{PERIOD_BITS{1'b0}}, 1'b1};
  assign fire      = count_inc >= {1'b0, period};

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (tick) begin
      timer <= fire ? '0 : count_inc[PERIOD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/tasd_core.sv]
// tasd_core: step counters, pins, coil sequencer and busy flag
// depends on tasd_pkg and tasd_divider
`default_nettype none

module tasd_core #(
  parameter int unsigned STEP_COUNT_BITS = tasd_pkg::STEP_COUNT_BITS_DEFAULT,
  parameter int unsigned PERIOD_BITS     = tasd_pkg::PERIOD_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic                       action,
  input  wire logic [STEP_COUNT_BITS-1:0] x_steps,
  input  wire logic [STEP_COUNT_BITS-1:0] y_steps,
  input  wire logic [STEP_COUNT_BITS-1:0] z_steps,
  input  wire logic                       x_direction,
  input  wire logic                       y_direction,
  input  wire logic                       z_lower,
  input  wire logic [PERIOD_BITS-1:0]     xy_period,
  input  wire logic [PERIOD_BITS-1:0]     z_period,
  output tasd_pkg::result_t               result
);

  logic [STEP_COUNT_BITS-1:0] x_left, y_left, z_left;
  logic [STEP_COUNT_BITS-1:0] x_left_next, y_left_next, z_left_next;
  logic x_pin, y_pin, x_dir_reg, y_dir_reg, lower_mode, busy_flag;
  logic x_pin_next, y_pin_next, x_dir_next, y_dir_next, lower_next, busy_next;
  logic [1:0] coil_phase, coil_phase_next;
  logic [3:0] coil_pattern, coil_pattern_next;
  logic tick, load, xy_fire, z_fire, xy_ev, z_ev, z_done;

  assign load = accept && (action == tasd_pkg::ACTION_LOAD);
  assign tick = accept && (action == tasd_pkg::ACTION_TICK);

  tasd_divider #(.PERIOD_BITS(PERIOD_BITS)) u_xy_div (
    .clk(clk), .rst(rst), .tick(tick), .period(xy_period), .fire(xy_fire)
  );

  tasd_divider #(.PERIOD_BITS(PERIOD_BITS)) u_z_div (
    .clk(clk), .rst(rst), .tick(tick), .period(z_period), .fire(z_fire)
  );

  assign xy_ev  = tick && xy_fire;
  assign z_ev   = tick && z_fire;
  assign z_done = (z_left == '0);

  always_comb begin
    x_left_next       = x_left;
    y_left_next       = y_left;
    z_left_next       = z_left;
    x_pin_next        = x_pin;
    y_pin_next        = y_pin;
    x_dir_next        = x_dir_reg;
    y_dir_next        = y_dir_reg;
    lower_next        = lower_mode;
    busy_next         = busy_flag;
    coil_phase_next   = coil_phase;
    coil_pattern_next = coil_pattern;
    if (load) begin
      x_left_next = x_steps;
      y_left_next = y_steps;
      z_left_next = z_steps;
      x_dir_next  = x_direction;
      y_dir_next  = y_direction;
      lower_next  = z_lower;
      busy_next   = 1'b1;
    end else begin
      if (xy_ev) begin
        if (z_done && (y_left != '0)) begin
          y_pin_next  = ~y_pin;
          y_left_next = y_left - {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
        end
        if (z_done && (x_left != '0)) begin
          x_pin_next  = ~x_pin;
          x_left_next = x_left - {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
        end
        if (z_done && (x_left_next == '0) && (y_left_next == '0)) begin
          busy_next = 1'b0;
        end
      end
      if (z_ev && !z_done) begin
        coil_pattern_next = tasd_pkg::coil_step(coil_phase, lower_mode);
        coil_phase_next   = coil_phase + 2'd1;
        z_left_next       = z_left - {{(STEP_COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_left       <= '0;
      y_left       <= '0;
      z_left       <= '0;
      x_pin        <= 1'b0;
      y_pin        <= 1'b0;
      x_dir_reg    <= 1'b0;
      y_dir_reg    <= 1'b0;
      lower_mode   <= 1'b0;
      busy_flag    <= 1'b0;
      coil_phase   <= 2'd0;
      coil_pattern <= tasd_pkg::COILS_OFF;
    end else begin
      x_left       <= x_left_next;
      y_left       <= y_left_next;
      z_left       <= z_left_next;
      x_pin        <= x_pin_next;
      y_pin        <= y_pin_next;
      x_dir_reg    <= x_dir_next;
      y_dir_reg    <= y_dir_next;
      lower_mode   <= lower_next;
      busy_flag    <= busy_next;
      coil_phase   <= coil_phase_next;
      coil_pattern <= coil_pattern_next;
    end
  end

  // state after this transaction
  assign result.x_step_pin = x_pin_next;
  assign result.y_step_pin = y_pin_next;
  assign result.x_dir_pin  = x_dir_next;
  assign result.y_dir_pin  = y_dir_next;
  assign result.z_coils    = coil_pattern_next;
  assign result.busy_res   = busy_next;

endmodule

`default_nettype wire

[hdl/tasd_out_buf.sv]
// tasd_out_buf: two-entry result register with skid stage
// depends on tasd_pkg
`default_nettype none

module tasd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tasd_pkg::result_t  push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tasd_pkg::result_t       out_data
);

  tasd_pkg::result_t main_data, skid_data;
  logic main_valid, skid_valid, pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

[hdl/three_axis_stepper_drive.sv]
// three_axis_stepper_drive: top level with configuration registers
// depends on tasd_pkg, tasd_core and tasd_out_buf
//
// Every transaction is either one clock tick or a load of a new move, and
// each gives one result: the pin levels, coil pattern and busy flag after
// it. One transaction is taken per cycle while in_stall is low; its
// result is registered in the output buffer. A two-entry output buffer
// lets input keep flowing past a stalled result until the skid entry
// fills; in_stall rises only when both entries hold results not yet taken.
// Period registers are written through the cfg port, which is always ready.
`default_nettype none

module three_axis_stepper_drive #(
  parameter int unsigned STEP_COUNT_BITS = tasd_pkg::STEP_COUNT_BITS_DEFAULT,
  parameter int unsigned PERIOD_BITS     = tasd_pkg::PERIOD_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       action,
  input  wire logic [STEP_COUNT_BITS-1:0] x_steps,
  input  wire logic [STEP_COUNT_BITS-1:0] y_steps,
  input  wire logic [STEP_COUNT_BITS-1:0] z_steps,
  input  wire logic                       x_direction,
  input  wire logic                       y_direction,
  input  wire logic                       z_lower,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            x_step_pin,
  output logic                            y_step_pin,
  output logic                            x_dir_pin,
  output logic                            y_dir_pin,
  output logic [3:0]                      z_coils,
  output logic                            busy_res,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [PERIOD_BITS-1:0]     cfg_data
);

  logic [PERIOD_BITS-1:0] xy_period, z_period;
  logic accept, buf_full;
  tasd_pkg::result_t core_result, out_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_period <= PERIOD_BITS'(tasd_pkg::XY_PERIOD_RESET);
      z_period  <= PERIOD_BITS'(tasd_pkg::Z_PERIOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tasd_pkg::CFG_XY_PERIOD: xy_period <= cfg_data;
        tasd_pkg::CFG_Z_PERIOD:  z_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  tasd_core #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .action(action),
    .x_steps(x_steps),
    .y_steps(y_steps),
    .z_steps(z_steps),
    .x_direction(x_direction),
    .y_direction(y_direction),
    .z_lower(z_lower),
    .xy_period(xy_period),
    .z_period(z_period),
    .result(core_result)
  );

  tasd_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .push_data(core_result),
    .full(buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  assign x_step_pin = out_data.x_step_pin;
  assign y_step_pin = out_data.y_step_pin;
  assign x_dir_pin  = out_data.x_dir_pin;
  assign y_dir_pin  = out_data.y_dir_pin;
  assign z_coils    = out_data.z_coils;
  assign busy_res   = out_data.busy_res;

endmodule

`default_nettype wire

[hdl/tasd_checker.sv]
// tasd_checker: port-level assertions for three_axis_stepper_drive
// depends on tasd_pkg; bound to the top level at the end of this file
`default_nettype none

module tasd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       action,
  input wire logic       x_direction,
  input wire logic       y_direction,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       x_step_pin,
  input wire logic       y_step_pin,
  input wire logic       x_dir_pin,
  input wire logic       y_dir_pin,
  input wire logic [3:0] z_coils,
  input wire logic       busy_res
);

  logic in_acc, load_into_empty;

  assign in_acc          = in_valid && !in_stall;
  assign load_into_empty = in_acc && !out_valid && (action == tasd_pkg::ACTION_LOAD);

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(z_coils) && $stable(busy_res)
      && $stable(x_step_pin) && $stable(y_step_pin))
    else $error("stalled result changed");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_load_sets_busy: assert property (@(posedge clk) disable iff (rst)
    load_into_empty |=> out_valid && busy_res)
    else $error("load did not give a busy result");

  a_load_sets_dirs: assert property (@(posedge clk) disable iff (rst)
    load_into_empty |=> x_dir_pin == $past(x_direction) && y_dir_pin == $past(y_direction))
    else $error("load did not set direction pins");

  a_coil_pattern_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> z_coils == tasd_pkg::COILS_OFF || z_coils == tasd_pkg::COILS_A
      || z_coils == tasd_pkg::COILS_B || z_coils == tasd_pkg::COILS_C
      || z_coils == tasd_pkg::COILS_D)
    else $error("coil pattern outside the full-step sequence");

endmodule

bind three_axis_stepper_drive tasd_checker u_tasd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .action(action),
  .x_direction(x_direction),
  .y_direction(y_direction),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .x_step_pin(x_step_pin),
  .y_step_pin(y_step_pin),
  .x_dir_pin(x_dir_pin),
  .y_dir_pin(y_dir_pin),
  .z_coils(z_coils),
  .busy_res(busy_res)
);

`default_nettype wire
